[src/assert_macros.svh]
// Assertion macros used by the checker module of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an asynchronous active-low reset that disables it.
`define CHK_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pd mixer check failed");

// Same, with a caller-supplied message string.
`define CHK_ASSERT_MSG(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

[src/pdm_pkg.sv]
// Package for the PD differential motor mixer: widths, register indexes,
// stage payload structs and the duty saturation function. No dependencies.
`timescale 1ns / 1ps

package pdm_pkg;

    localparam int ErrW   = 16;
    localparam int DiffW  = ErrW + 1;
    localparam int GainW  = 16;
    localparam int BaseW  = 8;
    localparam int DutyW  = 8;
    localparam int PProdW = GainW + 1 + ErrW;
    localparam int DProdW = GainW + 1 + DiffW;
    localparam int SumW   = DProdW + 1;
    localparam int PdW    = SumW - 8;
    localparam int MixW   = PdW + 1;
    localparam int IdxW   = 3;
    localparam int CfgW   = 16;

    localparam logic [GainW-1:0] KP_RESET   = 16'd256;
    localparam logic [GainW-1:0] KD_RESET   = 16'd0;
    localparam logic [BaseW-1:0] BASE_RESET = 8'd150;
    localparam logic [DutyW-1:0] DUTY_MAX   = 8'd255;

    localparam logic [IdxW-1:0] REG_KP_A = 3'd0;
    localparam logic [IdxW-1:0] REG_KD_A = 3'd1;
    localparam logic [IdxW-1:0] REG_KP_B = 3'd2;
    localparam logic [IdxW-1:0] REG_KD_B = 3'd3;
    localparam logic [IdxW-1:0] REG_KP_C = 3'd4;
    localparam logic [IdxW-1:0] REG_KD_C = 3'd5;
    localparam logic [IdxW-1:0] REG_BASE = 3'd6;

    localparam logic [1:0] GAIN_SET_A = 2'd0;
    localparam logic [1:0] GAIN_SET_B = 2'd1;
    localparam logic [1:0] GAIN_SET_C = 2'd2;

    typedef struct packed {
        logic [2:0][GainW-1:0] kp;
        logic [2:0][GainW-1:0] kd;
        logic [BaseW-1:0]      base;
    } cfg_t;

    typedef struct packed {
        logic signed [ErrW-1:0]  err;
        logic signed [DiffW-1:0] diff;
        logic [GainW-1:0]        kp;
        logic [GainW-1:0]        kd;
        logic                    stop;
    } s1_t;

    typedef struct packed {
        logic signed [PProdW-1:0] p_prod;
        logic signed [DProdW-1:0] d_prod;
        logic                     stop;
    } s2_t;

    typedef struct packed {
        logic             standby_active;
        logic             left_update;
        logic             left_reverse;
        logic [DutyW-1:0] left_duty;
        logic             right_update;
        logic             right_reverse;
        logic [DutyW-1:0] right_duty;
    } result_t;

    // Clamp a non-negative magnitude to the largest duty.
    function automatic logic [DutyW-1:0] sat_duty(input logic signed [MixW-1:0] mag);
        logic [DutyW-1:0] res;
        if (mag > $signed({{(MixW-DutyW){1'b0}}, DUTY_MAX}))
            res = DUTY_MAX;
        else
            res = mag[DutyW-1:0];
        return res;
    endfunction

endpackage

[src/pdm_cfg_regs.sv]
// Configuration register file: three gain sets and the base speed.
// Depends on pdm_pkg.
`timescale 1ns / 1ps

module pdm_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pdm_pkg::IdxW-1:0]       cfg_index,
    input  logic [pdm_pkg::CfgW-1:0]       cfg_data,
    output pdm_pkg::cfg_t                  cfg
);

    pdm_pkg::cfg_t cfg_reg;
    pdm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                pdm_pkg::REG_KP_A: cfg_next.kp[0] = cfg_data;
                pdm_pkg::REG_KD_A: cfg_next.kd[0] = cfg_data;
                pdm_pkg::REG_KP_B: cfg_next.kp[1] = cfg_data;
                pdm_pkg::REG_KD_B: cfg_next.kd[1] = cfg_data;
                pdm_pkg::REG_KP_C: cfg_next.kp[2] = cfg_data;
                pdm_pkg::REG_KD_C: cfg_next.kd[2] = cfg_data;
                pdm_pkg::REG_BASE: cfg_next.base  = cfg_data[pdm_pkg::BaseW-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp   <= {3{pdm_pkg::KP_RESET}};
            cfg_reg.kd   <= {3{pdm_pkg::KD_RESET}};
            cfg_reg.base <= pdm_pkg::BASE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/pdm_input_stage.sv]
// Input register stage: captures the request, picks the gain set, forms the
// error difference and keeps the previous error. Depends on pdm_pkg.
`timescale 1ns / 1ps

module pdm_input_stage
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic signed [pdm_pkg::ErrW-1:0] error_sample,
    input  logic                            stop_request,
    input  logic [1:0]                      gain_select,
    input  pdm_pkg::cfg_t                   cfg,
    input  logic                            down_ready,
    output logic                            ready,
    output logic                            valid,
    output pdm_pkg::s1_t                    data
);

    logic                            valid_reg;
    logic signed [pdm_pkg::ErrW-1:0] prev_error_reg;
    pdm_pkg::s1_t                    s1_reg;
    pdm_pkg::s1_t                    s1_next;

    assign ready = !valid_reg || down_ready;

    always_comb
    begin
        s1_next.err  = error_sample;
        s1_next.diff = {error_sample[pdm_pkg::ErrW-1], error_sample}
                     - {prev_error_reg[pdm_pkg::ErrW-1], prev_error_reg};
        s1_next.stop = stop_request;
        // Selector value three falls back to the last gain set.
        case (gain_select)
            pdm_pkg::GAIN_SET_A:
            begin
                s1_next.kp = cfg.kp[0];
                s1_next.kd = cfg.kd[0];
            end
            pdm_pkg::GAIN_SET_B:
            begin
                s1_next.kp = cfg.kp[1];
                s1_next.kd = cfg.kd[1];
            end
            default:
            begin
                s1_next.kp = cfg.kp[2];
                s1_next.kd = cfg.kd[2];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            prev_error_reg <= '0;
        end
        else if (ready)
        begin
            valid_reg <= in_valid;
            if (in_valid && !stop_request)
                prev_error_reg <= error_sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && in_valid)
            s1_reg <= s1_next;
    end

    assign valid = valid_reg;
    assign data  = s1_reg;

endmodule

[src/pdm_product_stage.sv]
// Product stage: the proportional and derivative multiplications, each
// registered. Depends on pdm_pkg.
`timescale 1ns / 1ps

module pdm_product_stage
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    input  pdm_pkg::s1_t  up_data,
    input  logic          down_ready,
    output logic          ready,
    output logic          valid,
    output pdm_pkg::s2_t  data
);

    logic         valid_reg;
    pdm_pkg::s2_t s2_reg;
    pdm_pkg::s2_t s2_next;

    assign ready = !valid_reg || down_ready;

    always_comb
    begin
        // Gains are unsigned, so a zero sign bit is prepended before the signed multiply.
        s2_next.p_prod = $signed({1'b0, up_data.kp}) * up_data.err;
        s2_next.d_prod = $signed({1'b0, up_data.kd}) * up_data.diff;
        s2_next.stop   = up_data.stop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ready && up_valid)
            s2_reg <= s2_next;
    end

    assign valid = valid_reg;
    assign data  = s2_reg;

endmodule

[src/pdm_mix_stage.sv]
// Mix stage: sums the products, scales by 1/256 toward zero, mixes around
// the base speed and registers the motor result. Depends on pdm_pkg.
`timescale 1ns / 1ps

module pdm_mix_stage
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        up_valid,
    input  pdm_pkg::s2_t                up_data,
    input  logic [pdm_pkg::BaseW-1:0]   base,
    input  logic                        out_stall,
    output logic                        ready,
    output logic                        valid,
    output pdm_pkg::result_t            result
);

    logic                              valid_reg;
    pdm_pkg::result_t                  res_reg;
    pdm_pkg::result_t                  res_next;
    logic signed [pdm_pkg::SumW-1:0]   sum;
    logic signed [pdm_pkg::SumW-1:0]   biased;
    logic signed [pdm_pkg::PdW-1:0]    pd;
    logic signed [pdm_pkg::MixW-1:0]   base_ext;
    logic signed [pdm_pkg::MixW-1:0]   left;
    logic signed [pdm_pkg::MixW-1:0]   right;

    assign ready = !valid_reg || !out_stall;

    always_comb
    begin
        sum = {{(pdm_pkg::SumW-pdm_pkg::PProdW){up_data.p_prod[pdm_pkg::PProdW-1]}},
               up_data.p_prod}
            + {{(pdm_pkg::SumW-pdm_pkg::DProdW){up_data.d_prod[pdm_pkg::DProdW-1]}},
               up_data.d_prod};
        // A bias of 255 on negative sums makes the arithmetic shift truncate toward zero.
        biased   = sum + (sum[pdm_pkg::SumW-1] ? pdm_pkg::SumW'(255) : '0);
        pd       = biased[pdm_pkg::SumW-1:8];
        base_ext = $signed({{(pdm_pkg::MixW-pdm_pkg::BaseW){1'b0}}, base});
        left     = base_ext + {pd[pdm_pkg::PdW-1], pd};
        right    = base_ext - {pd[pdm_pkg::PdW-1], pd};

        res_next = '0;
        if (up_data.stop)
        begin
            res_next.standby_active = 1'b1;
        end
        else if (left[pdm_pkg::MixW-1])
        begin
            res_next.left_update  = 1'b1;
            res_next.left_reverse = 1'b1;
            res_next.left_duty    = pdm_pkg::sat_duty(-left);
        end
        else if (right[pdm_pkg::MixW-1])
        begin
            res_next.right_update  = 1'b1;
            res_next.right_reverse = 1'b1;
            res_next.right_duty    = pdm_pkg::sat_duty(-right);
        end
        else
        begin
            res_next.left_update  = 1'b1;
            res_next.left_duty    = pdm_pkg::sat_duty(left);
            res_next.right_update = 1'b1;
            res_next.right_duty   = pdm_pkg::sat_duty(right);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ready && up_valid)
            res_reg <= res_next;
    end

    assign valid  = valid_reg;
    assign result = res_reg;

endmodule

[src/pd_differential_motor_mixer_top.sv]
// PD differential motor mixer, top level. Uses pdm_pkg and the pdm_* stages.
// Pipeline: an accepted request passes the input, product and mix stage registers in turn to out_valid.
// Throughput: one request per cycle; each stage holds while its successor is full.
// Reset (rst_n low, asynchronous): pipeline empties, previous error clears to zero,
// gains return to Kp = 1.0 and Kd = 0 in all sets, base speed returns to 150.
`timescale 1ns / 1ps

module pd_differential_motor_mixer_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port.
    input  logic                               cfg_we,
    input  logic [pdm_pkg::IdxW-1:0]           cfg_index,
    input  logic [pdm_pkg::CfgW-1:0]           cfg_data,
    // Input request channel.
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [pdm_pkg::ErrW-1:0]    error_sample,
    input  logic                               stop_request,
    input  logic [1:0]                         gain_select,
    // Result channel.
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               standby_active,
    output logic                               left_update,
    output logic                               left_reverse,
    output logic [pdm_pkg::DutyW-1:0]          left_duty,
    output logic                               right_update,
    output logic                               right_reverse,
    output logic [pdm_pkg::DutyW-1:0]          right_duty
);

    pdm_pkg::cfg_t    cfg;
    pdm_pkg::s1_t     s1_data;
    pdm_pkg::s2_t     s2_data;
    pdm_pkg::result_t result;
    logic             s1_ready;
    logic             s1_valid;
    logic             s2_ready;
    logic             s2_valid;
    logic             s3_ready;

    // The user must change gains and base speed only while the block is idle; the block
    // does not enforce it. The input and mix stages read them straight from the register file.
    pdm_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The previous error is updated at the moment a running request is accepted,
    // so back-to-back requests see each other's errors in order.
    pdm_input_stage u_input
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .error_sample (error_sample),
        .stop_request (stop_request),
        .gain_select  (gain_select),
        .cfg          (cfg),
        .down_ready   (s2_ready),
        .ready        (s1_ready),
        .valid        (s1_valid),
        .data         (s1_data)
    );

    pdm_product_stage u_product
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (s1_valid),
        .up_data    (s1_data),
        .down_ready (s3_ready),
        .ready      (s2_ready),
        .valid      (s2_valid),
        .data       (s2_data)
    );

    // The mix stage's register is the output register; a stalled result holds
    // there while earlier stages keep filling until the pipeline is full.
    pdm_mix_stage u_mix
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (s2_valid),
        .up_data   (s2_data),
        .base      (cfg.base),
        .out_stall (out_stall),
        .ready     (s3_ready),
        .valid     (out_valid),
        .result    (result)
    );

    assign in_stall       = !s1_ready;
    assign standby_active = result.standby_active;
    assign left_update    = result.left_update;
    assign left_reverse   = result.left_reverse;
    assign left_duty      = result.left_duty;
    assign right_update   = result.right_update;
    assign right_reverse  = result.right_reverse;
    assign right_duty     = result.right_duty;

endmodule

[src/pdm_checker.sv]
// Port-level checker for the PD differential motor mixer, bound to the top level.
// Depends on assert_macros.svh and pdm_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pdm_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic                        standby_active,
    input logic                        left_update,
    input logic                        left_reverse,
    input logic [pdm_pkg::DutyW-1:0]   left_duty,
    input logic                        right_update,
    input logic                        right_reverse,
    input logic [pdm_pkg::DutyW-1:0]   right_duty
);

    `CHK_ASSERT(a_stall_holds, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(left_duty) && $stable(right_duty))
    `CHK_ASSERT_MSG(a_standby_quiet, clk, rst_n, out_valid && standby_active |-> !left_update && !right_update && !left_reverse && !right_reverse && left_duty == 0 && right_duty == 0, "standby result drives a motor")
    `CHK_ASSERT_MSG(a_run_drives, clk, rst_n, out_valid && !standby_active |-> left_update || right_update, "running result drives no motor")
    `CHK_ASSERT(a_left_rev_alone, clk, rst_n, out_valid && left_reverse |-> left_update && !right_update && !right_reverse && right_duty == 0)
    `CHK_ASSERT(a_right_rev_alone, clk, rst_n, out_valid && right_reverse |-> right_update && !left_update && !left_reverse && left_duty == 0)

endmodule

bind pd_differential_motor_mixer_top pdm_checker u_pdm_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .standby_active (standby_active),
    .left_update    (left_update),
    .left_reverse   (left_reverse),
    .left_duty      (left_duty),
    .right_update   (right_update),
    .right_reverse  (right_reverse),
    .right_duty     (right_duty)
);

[dv/testbench.sv]
// Self-checking testbench for pd_differential_motor_mixer_top: directed and random
// requests with random gaps and output stalls, checked against an in-bench predictor.
// Depends on pdm_pkg and the RTL of the mixer; reads no files.
`timescale 1ns / 1ps

module testbench;

    // Index past the last register; writes there must leave every gain and the
    // base speed untouched.
    localparam logic [pdm_pkg::IdxW-1:0] REG_SPARE = 3'd7;
    // Selector value above the last gain set; the block clamps it to set two.
    localparam logic [1:0] GAIN_SET_OVER = 2'd3;
    // Cycles to let pass once nothing is pending, a little over the pipeline depth.
    localparam int SETTLE_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                             cfg_we = 1'b0;
    logic [pdm_pkg::IdxW-1:0]         cfg_index = '0;
    logic [pdm_pkg::CfgW-1:0]         cfg_data = '0;

    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic signed [pdm_pkg::ErrW-1:0]  error_sample = '0;
    logic                             stop_request = 1'b0;
    logic [1:0]                       gain_select = '0;

    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic                             standby_active;
    logic                             left_update;
    logic                             left_reverse;
    logic [pdm_pkg::DutyW-1:0]        left_duty;
    logic                             right_update;
    logic                             right_reverse;
    logic [pdm_pkg::DutyW-1:0]        right_duty;

    pd_differential_motor_mixer_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .error_sample   (error_sample),
        .stop_request   (stop_request),
        .gain_select    (gain_select),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .standby_active (standby_active),
        .left_update    (left_update),
        .left_reverse   (left_reverse),
        .left_duty      (left_duty),
        .right_update   (right_update),
        .right_reverse  (right_reverse),
        .right_duty     (right_duty)
    );

    always #5 clk = ~clk;

    // Shadow copy of the block's registers and its error memory. These follow
    // every configuration write and every accepted request.
    logic [pdm_pkg::GainW-1:0]        kp_shadow [3];
    logic [pdm_pkg::GainW-1:0]        kd_shadow [3];
    logic [pdm_pkg::BaseW-1:0]        base_shadow;
    logic signed [pdm_pkg::ErrW-1:0]  last_error;

    // Motor commands predicted for accepted requests, oldest first.
    pdm_pkg::result_t motor_cmd_queue [$];
    int               mismatch_count = 0;

    // When set, the sender puts requests back to back with no gaps.
    bit      send_bursty = 1'b0;
    // Last error sent, used to build slowly drifting error sequences.
    int      drift_error = 0;

    // Length of one idle or stall stretch, drawn at random, with long stretches rare.
    function automatic int hold_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 1;
        else if (roll < 92)
            return $urandom_range(2, 4);
        return $urandom_range(6, 25);
    endfunction

    function automatic logic [pdm_pkg::DutyW-1:0] clip_duty(input longint magnitude);
        if (magnitude > longint'(pdm_pkg::DUTY_MAX))
            return pdm_pkg::DUTY_MAX;
        return magnitude[pdm_pkg::DutyW-1:0];
    endfunction

    // Works out the motor command for one accepted request and advances the
    // error memory. A stop request parks both motors and keeps the memory.
    function automatic pdm_pkg::result_t mix_predict(
        input logic signed [pdm_pkg::ErrW-1:0] err,
        input logic stop,
        input logic [1:0] sel);
        pdm_pkg::result_t cmd;
        int      set_idx;
        longint  delta;
        longint  weighted;
        longint  steer;
        longint  left_mix;
        longint  right_mix;
        cmd = '0;
        if (stop)
        begin
            cmd.standby_active = 1'b1;
            return cmd;
        end
        set_idx = (sel > pdm_pkg::GAIN_SET_C) ? int'(pdm_pkg::GAIN_SET_C) : int'(sel);
        delta = longint'(err) - longint'(last_error);
        weighted = longint'(kp_shadow[set_idx]) * longint'(err)
                 + longint'(kd_shadow[set_idx]) * delta;
        // Integer division rounds toward zero, which is the Q8.8 truncation wanted.
        steer = weighted / 256;
        last_error = err;
        left_mix = longint'(base_shadow) + steer;
        right_mix = longint'(base_shadow) - steer;
        if (left_mix < 0)
        begin
            cmd.left_update = 1'b1;
            cmd.left_reverse = 1'b1;
            cmd.left_duty = clip_duty(-left_mix);
        end
        else if (right_mix < 0)
        begin
            cmd.right_update = 1'b1;
            cmd.right_reverse = 1'b1;
            cmd.right_duty = clip_duty(-right_mix);
        end
        else
        begin
            cmd.left_update = 1'b1;
            cmd.left_duty = clip_duty(left_mix);
            cmd.right_update = 1'b1;
            cmd.right_duty = clip_duty(right_mix);
        end
        return cmd;
    endfunction

    // One configuration write, then the shadow registers follow it.
    task automatic write_reg(input logic [pdm_pkg::IdxW-1:0] idx,
                             input logic [pdm_pkg::CfgW-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            pdm_pkg::REG_KP_A: kp_shadow[0] = value;
            pdm_pkg::REG_KD_A: kd_shadow[0] = value;
            pdm_pkg::REG_KP_B: kp_shadow[1] = value;
            pdm_pkg::REG_KD_B: kd_shadow[1] = value;
            pdm_pkg::REG_KP_C: kp_shadow[2] = value;
            pdm_pkg::REG_KD_C: kd_shadow[2] = value;
            pdm_pkg::REG_BASE: base_shadow = value[pdm_pkg::BaseW-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Sends one request, with a random gap ahead of it unless bursting. The
    // valid stays high after acceptance so that back-to-back requests never
    // drop it; settle() lowers it.
    task automatic send_sample(input logic signed [pdm_pkg::ErrW-1:0] err,
                               input logic stop,
                               input logic [1:0] sel);
        int gap;
        gap = 0;
        if (!send_bursty && $urandom_range(0, 99) >= 50)
            gap = hold_cycles();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        error_sample <= err;
        stop_request <= stop;
        gain_select <= sel;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        motor_cmd_queue.push_back(mix_predict(err, stop, sel));
    endtask

    // Brings the block to idle: no request offered, every command back, and
    // the pipeline given time to empty before registers change.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (motor_cmd_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Reset values: unit proportional gain, no derivative, base speed 150.
    // Covers both steering directions, saturation, a stop and the clamped
    // selector before any register is touched.
    task automatic test_reset_defaults();
        send_sample(16'sd0, 1'b0, pdm_pkg::GAIN_SET_A);
        send_sample(16'sd100, 1'b0, pdm_pkg::GAIN_SET_B);
        send_sample(16'sd200, 1'b0, pdm_pkg::GAIN_SET_C);
        send_sample(-16'sd32768, 1'b0, GAIN_SET_OVER);
        send_sample(16'sd32767, 1'b1, pdm_pkg::GAIN_SET_A);
        send_sample(16'sd32767, 1'b0, pdm_pkg::GAIN_SET_A);
        settle();
    endtask

    // Largest and zero gains, full-scale errors and base speed at its top.
    // A write to the spare index must not disturb the base speed. Stops in
    // between must leave the error memory as it was.
    task automatic test_gain_extremes();
        write_reg(pdm_pkg::REG_KP_A, 16'hFFFF);
        write_reg(pdm_pkg::REG_KD_A, 16'hFFFF);
        write_reg(pdm_pkg::REG_KP_B, 16'h0000);
        write_reg(pdm_pkg::REG_KD_B, 16'h0000);
        write_reg(pdm_pkg::REG_KP_C, 16'h0000);
        write_reg(pdm_pkg::REG_KD_C, 16'hFFFF);
        write_reg(pdm_pkg::REG_BASE, 16'h00FF);
        write_reg(REG_SPARE, 16'h0000);
        send_sample(16'sd32767, 1'b0, pdm_pkg::GAIN_SET_A);
        send_sample(-16'sd32768, 1'b0, pdm_pkg::GAIN_SET_A);
        send_sample(16'sd1234, 1'b0, pdm_pkg::GAIN_SET_B);
        send_sample(16'sd12345, 1'b1, pdm_pkg::GAIN_SET_C);
        send_sample(-16'sd1, 1'b0, pdm_pkg::GAIN_SET_C);
        send_sample(16'sd1, 1'b0, GAIN_SET_OVER);
        send_sample(-16'sd20000, 1'b1, pdm_pkg::GAIN_SET_A);
        send_sample(16'sd1, 1'b0, GAIN_SET_OVER);
        settle();
    endtask

    // Base speed zero, so the smallest steering reverses one wheel, and a
    // tiny gain where the product truncates toward zero from both sides.
    task automatic test_base_zero();
        write_reg(pdm_pkg::REG_BASE, 16'h0000);
        write_reg(pdm_pkg::REG_KP_A, pdm_pkg::KP_RESET);
        write_reg(pdm_pkg::REG_KD_A, pdm_pkg::KD_RESET);
        write_reg(pdm_pkg::REG_KP_B, 16'h0001);
        send_sample(16'sd0, 1'b0, pdm_pkg::GAIN_SET_A);
        send_sample(16'sd1, 1'b0, pdm_pkg::GAIN_SET_A);
        send_sample(-16'sd1, 1'b0, pdm_pkg::GAIN_SET_A);
        send_sample(-16'sd255, 1'b0, pdm_pkg::GAIN_SET_B);
        send_sample(16'sd255, 1'b0, pdm_pkg::GAIN_SET_B);
        settle();
    endtask

    function automatic logic [pdm_pkg::GainW-1:0] pick_gain();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return '0;
        else if (roll < 20)
            return '1;
        else if (roll < 60)
            return pdm_pkg::GainW'($urandom_range(0, 600));
        else if (roll < 80)
            return pdm_pkg::GainW'($urandom_range(0, 4095));
        return pdm_pkg::GainW'($urandom());
    endfunction

    // Most errors are small or drift slowly like a real line sensor, so duties
    // land inside the range; the rest sweep the full width and its ends.
    function automatic logic signed [pdm_pkg::ErrW-1:0] pick_error();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            drift_error = $urandom_range(0, 800) - 400;
        else if (roll < 65)
            drift_error = drift_error + $urandom_range(0, 80) - 40;
        else if (roll < 90)
            drift_error = $signed(16'($urandom()));
        else if (roll < 95)
            drift_error = 32767 - $urandom_range(0, 3);
        else
            drift_error = -32768 + $urandom_range(0, 3);
        if (drift_error > 32767)
            drift_error = 32767;
        if (drift_error < -32768)
            drift_error = -32768;
        return pdm_pkg::ErrW'(drift_error);
    endfunction

    // Several phases, each with fresh register settings loaded while idle and
    // a few hundred random requests. The first two pin the base speed to its
    // ends; one phase runs with no sender gaps at all.
    task automatic test_random_traffic();
        logic [pdm_pkg::CfgW-1:0] base_value;
        for (int phase = 0; phase < 6; phase++)
        begin
            settle();
            write_reg(pdm_pkg::REG_KP_A, pick_gain());
            write_reg(pdm_pkg::REG_KD_A, pick_gain());
            write_reg(pdm_pkg::REG_KP_B, pick_gain());
            write_reg(pdm_pkg::REG_KD_B, pick_gain());
            write_reg(pdm_pkg::REG_KP_C, pick_gain());
            write_reg(pdm_pkg::REG_KD_C, pick_gain());
            if (phase == 0)
                base_value = '0;
            else if (phase == 1)
                base_value = 16'h00FF;
            else
                base_value = pdm_pkg::CfgW'($urandom());
            write_reg(pdm_pkg::REG_BASE, base_value);
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_SPARE, pdm_pkg::CfgW'($urandom()));
            for (int n = 0; n < 305; n++)
            begin
                if (n % 60 == 0)
                    send_bursty = (phase == 2) || ($urandom_range(0, 4) == 0);
                send_sample(pick_error(), $urandom_range(0, 9) == 0,
                            2'($urandom_range(0, 3)));
            end
        end
        send_bursty = 1'b0;
        settle();
    endtask

    // Output stalls: random stretches, with quiet spells in which the result
    // side takes everything as it comes.
    int stall_left = 0;
    int quiet_left = 0;
    always @(negedge clk)
    begin : drive_out_stall
        int roll;
        if (quiet_left > 0)
        begin
            quiet_left--;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
            begin
                quiet_left = $urandom_range(20, 120);
                out_stall <= 1'b0;
            end
            else if (roll < 32)
            begin
                stall_left = hold_cycles() - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Every accepted result is matched against the oldest pending command.
    always @(posedge clk)
    begin : check_motor_cmd
        pdm_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (motor_cmd_queue.size() == 0)
            begin
                $error("result arrived with no request pending");
                mismatch_count++;
            end
            else
            begin
                want = motor_cmd_queue.pop_front();
                compare_field("standby_active", want.standby_active, standby_active);
                compare_field("left_update", want.left_update, left_update);
                compare_field("left_reverse", want.left_reverse, left_reverse);
                compare_field("left_duty", want.left_duty, left_duty);
                compare_field("right_update", want.right_update, right_update);
                compare_field("right_reverse", want.right_reverse, right_reverse);
                compare_field("right_duty", want.right_duty, right_duty);
            end
        end
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        for (int s = 0; s < 3; s++)
        begin
            kp_shadow[s] = pdm_pkg::KP_RESET;
            kd_shadow[s] = pdm_pkg::KD_RESET;
        end
        base_shadow = pdm_pkg::BASE_RESET;
        last_error = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_gain_extremes();
        test_base_zero();
        test_random_traffic();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
